// ===== hw/rtl/lote_pkg.sv =====
`default_nettype none

package lote_pkg;

  // Fraction bits of the internal log/exp mantissa
  localparam int IFRAC = 30;
  // Number of squaring / root-multiply steps
  localparam int NumIter = 30;

  localparam logic signed [31:0] SAT_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

  // Configuration register indexes
  localparam logic [2:0] REG_INVERSE_MODE = 3'd0;
  localparam logic [2:0] REG_OFFSET_A     = 3'd1;
  localparam logic [2:0] REG_OFFSET_B     = 3'd2;
  localparam logic [2:0] REG_LOG_GAIN     = 3'd3;
  localparam logic [2:0] REG_TOE_SLOPE    = 3'd4;
  localparam logic [2:0] REG_TOE_CUT      = 3'd5;

  // Which path a word takes through the pipeline
  typedef enum logic [1:0] {
    KIND_TOE,
    KIND_LOG,
    KIND_EXP,
    KIND_CONST
  } lote_kind_e;

  // Word carried through the iteration chain
  typedef struct packed {
    lote_kind_e         kind;
    logic signed [31:0] word;   // finished result for toe/const words
    logic [4:0]         p;      // log: msb position of x + a
    logic signed [6:0]  k;      // exp: binary exponent, clamped low
    logic               k_big;  // exp: scale leaves the range
    logic [30:0]        m;      // mantissa, IFRAC fraction bits
    logic [29:0]        bits;   // log: fraction out, exp: fraction in
  } lote_iter_t;

  // Configuration register file
  typedef struct packed {
    logic               inverse_mode;
    logic [30:0]        offset_a;
    logic signed [31:0] offset_b;
    logic [30:0]        log_gain;
    logic [30:0]        toe_slope;
    logic signed [31:0] toe_cut;
  } lote_cfg_t;

  // Integer square root, used at elaboration only
  function automatic logic [63:0] lote_isqrt(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] b;
    rem = v;
    res = '0;
    b   = 64'h4000_0000_0000_0000;
    for (int j = 0; j < 32; j++) begin
      if (rem >= res + b) begin
        rem = rem - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // 2^(2^-i) in IFRAC fraction bits, by repeated floor square roots
  function automatic logic [30:0] lote_root(input int i);
    logic [63:0] r;
    r = 64'd2 << IFRAC;
    for (int j = 1; j <= NumIter; j++) begin
      if (j <= i) begin
        r = lote_isqrt(r << IFRAC);
      end
    end
    return r[30:0];
  endfunction

  // Saturate to the signed 32-bit range
  function automatic logic signed [31:0] lote_sat32(input logic signed [63:0] v);
    logic signed [31:0] y;
    if (v > 64'(SAT_MAX)) begin
      y = SAT_MAX;
    end else if (v < 64'(SAT_MIN)) begin
      y = SAT_MIN;
    end else begin
      y = v[31:0];
    end
    return y;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lote_front.sv =====
`default_nettype none

module lote_front #(
  parameter int FRAC_BITS = 24
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      en_i,
  input  wire lote_pkg::lote_cfg_t cfg_i,
  input  wire                      valid_i,
  input  wire logic signed [31:0]  sample_in_i,
  output logic                     valid_o,
  output lote_pkg::lote_iter_t     data_o
);
  import lote_pkg::*;

  // Stage 0: input register
  logic               v0_q;
  logic signed [31:0] x0_q;

  // Stage 1: shared multiplier, log offset add
  logic               v1_q;
  lote_kind_e         kind1_d, kind1_q;
  logic signed [63:0] prod1_d, prod1_q;
  logic signed [32:0] s1_d, s1_q;
  logic               is_toe1;
  logic [30:0]        mul_b1;

  // Stage 2: toe rounding, exp offset, leading one search
  logic               v2_q;
  lote_kind_e         kind2_d, kind2_q;
  logic signed [31:0] word2_d, word2_q;
  logic signed [63:0] e2_d, e2_q;
  logic [31:0]        s2_q;
  logic [4:0]         p2_d, p2_q;
  logic signed [63:0] toe_r2;

  // Stage 3: normalize, exponent split
  logic               v3_q;
  lote_iter_t         d3_d, d3_q;
  logic [31:0]        norm3;
  logic signed [63:0] n3, k3;
  logic [2*FRAC_BITS+29:0] ftmp3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= valid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Stage 1: one multiplier serves toe slope and exp gain
  always_comb begin
    is_toe1 = (x0_q <= cfg_i.toe_cut);
    mul_b1  = is_toe1 ? cfg_i.toe_slope : cfg_i.log_gain;
    prod1_d = 64'(x0_q) * 64'($signed({1'b0, mul_b1}));
    s1_d    = 33'(x0_q) + 33'($signed({1'b0, cfg_i.offset_a}));
    if (is_toe1) begin
      kind1_d = KIND_TOE;
    end else if (cfg_i.inverse_mode) begin
      kind1_d = KIND_EXP;
    end else begin
      kind1_d = KIND_LOG;
    end
  end

  // Stage 2
  always_comb begin
    toe_r2  = (prod1_q + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    e2_d    = prod1_q - (64'(cfg_i.offset_b) <<< FRAC_BITS);
    kind2_d = kind1_q;
    word2_d = lote_sat32(toe_r2);
    if (kind1_q == KIND_LOG && s1_q <= 33'sd0) begin
      kind2_d = KIND_CONST;
      word2_d = SAT_MIN;
    end
    // highest set bit wins
    p2_d = '0;
    for (int i = 0; i < 32; i++) begin
      if (s1_q[i]) begin
        p2_d = 5'(i);
      end
    end
  end

  // Stage 3
  always_comb begin
    norm3 = s2_q << (5'd31 - p2_q);
    n3    = e2_q >>> (2 * FRAC_BITS);
    k3    = n3 + 64'(FRAC_BITS - IFRAC);
    ftmp3 = {e2_q[2*FRAC_BITS-1:0], 30'b0};

    d3_d.kind  = kind2_q;
    d3_d.word  = word2_q;
    d3_d.p     = p2_q;
    d3_d.k_big = (k3 >= 64'sd3);
    d3_d.k     = (k3 < -64'sd41) ? -7'sd41 : 7'(k3);
    if (kind2_q == KIND_EXP) begin
      d3_d.m    = 31'(1) << IFRAC;
      d3_d.bits = ftmp3[2*FRAC_BITS+29 -: 30];
    end else begin
      d3_d.m    = norm3[31:1];
      d3_d.bits = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x0_q    <= sample_in_i;
      kind1_q <= kind1_d;
      prod1_q <= prod1_d;
      s1_q    <= s1_d;
      kind2_q <= kind2_d;
      word2_q <= word2_d;
      e2_q    <= e2_d;
      s2_q    <= s1_q[31:0];
      p2_q    <= p2_d;
      d3_q    <= d3_d;
    end
  end

  assign valid_o = v3_q;
  assign data_o  = d3_q;

endmodule

`default_nettype wire

// ===== hw/rtl/lote_iter_stage.sv =====
`default_nettype none

module lote_iter_stage #(
  parameter int STAGE = 1
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       en_i,
  input  wire                       valid_i,
  input  wire lote_pkg::lote_iter_t data_i,
  output logic                      valid_o,
  output lote_pkg::lote_iter_t      data_o
);
  import lote_pkg::*;

  localparam logic [30:0] Root = lote_root(STAGE);

  logic        v_q;
  lote_iter_t  d_d, d_q;
  logic [30:0] mul_b;
  logic [61:0] prod;
  logic [31:0] sq;

  // Log squares the mantissa, exp multiplies by this stage's root when its fraction bit is set
  always_comb begin
    mul_b = (data_i.kind == KIND_LOG) ? data_i.m : Root;
    prod  = 62'(data_i.m) * 62'(mul_b);
    sq    = prod[61:30];
    d_d      = data_i;
    d_d.bits = {data_i.bits[28:0], 1'b0};
    if (data_i.kind == KIND_LOG) begin
      if (sq[31]) begin
        d_d.m       = sq[31:1];
        d_d.bits[0] = 1'b1;
      end else begin
        d_d.m = sq[30:0];
      end
    end else if (data_i.kind == KIND_EXP && data_i.bits[29]) begin
      d_d.m = sq[30:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q <= d_d;
    end
  end

  assign valid_o = v_q;
  assign data_o  = d_q;

endmodule

`default_nettype wire

// ===== hw/rtl/lote_back.sv =====
`default_nettype none

module lote_back #(
  parameter int FRAC_BITS = 24
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       en_i,
  input  wire lote_pkg::lote_cfg_t  cfg_i,
  input  wire                       valid_i,
  input  wire lote_pkg::lote_iter_t data_i,
  output logic                      valid_o,
  output logic signed [31:0]        word_o
);
  import lote_pkg::*;

  logic v1_q, v2_q, v3_q, v4_q;

  // Stage 1: log sum, exp scaling
  lote_kind_e         kind1_q;
  logic signed [31:0] word1_q;
  logic               big1_q;
  logic signed [55:0] pm1, lg1_d, lg1_q;
  logic [5:0]         sh1;
  logic [63:0]        pw64;
  logic [33:0]        pw1_d, pw1_q;

  // Stage 2: magnitude split, exp offset
  lote_kind_e         kind2_q;
  logic signed [31:0] word2_d, word2_q;
  logic               neg2_q;
  logic [55:0]        mag2;
  logic [23:0]        hi2_q;
  logic [31:0]        lo2_q;

  // Stage 3: partial products
  lote_kind_e         kind3_q;
  logic signed [31:0] word3_q;
  logic               neg3_q;
  logic [54:0]        ph3_q;
  logic [62:0]        pl3_q;

  // Stage 4: round and saturate
  logic signed [31:0] word4_d, word4_q;
  logic [63:0]        r4;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // Stage 1
  always_comb begin
    pm1   = 56'($signed({1'b0, data_i.p})) - 56'(FRAC_BITS);
    lg1_d = (pm1 <<< IFRAC) + $signed(56'(data_i.bits))
          + (56'(cfg_i.offset_b) <<< (IFRAC - FRAC_BITS));
    sh1   = 6'(-data_i.k);
    if (data_i.k < 7'sd0) begin
      pw64 = (64'(data_i.m) + (64'd1 << (sh1 - 6'd1))) >> sh1;
    end else begin
      pw64 = 64'(data_i.m) << data_i.k[1:0];
    end
    pw1_d = pw64[33:0];
  end

  // Stage 2
  always_comb begin
    mag2    = lg1_q[55] ? 56'(-lg1_q) : 56'(lg1_q);
    word2_d = word1_q;
    if (kind1_q == KIND_EXP) begin
      if (big1_q) begin
        word2_d = SAT_MAX;
      end else begin
        word2_d = lote_sat32($signed(64'(pw1_q)) - $signed(64'(cfg_i.offset_a)));
      end
    end
  end

  // Stage 4: hi*c*4 plus rounded lo*c / 2^30
  always_comb begin
    r4 = (64'(ph3_q) << 2) + ((64'(pl3_q) + (64'd1 << (IFRAC - 1))) >> IFRAC);
    word4_d = word3_q;
    if (kind3_q == KIND_LOG) begin
      if (neg3_q) begin
        word4_d = (r4 > 64'h8000_0000) ? SAT_MIN : 32'(-r4);
      end else begin
        word4_d = (r4 > 64'h7fff_ffff) ? SAT_MAX : 32'(r4);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      kind1_q <= data_i.kind;
      word1_q <= data_i.word;
      big1_q  <= data_i.k_big;
      lg1_q   <= lg1_d;
      pw1_q   <= pw1_d;

      kind2_q <= (kind1_q == KIND_EXP) ? KIND_CONST : kind1_q;
      word2_q <= word2_d;
      neg2_q  <= lg1_q[55];
      hi2_q   <= mag2[55:32];
      lo2_q   <= mag2[31:0];

      kind3_q <= kind2_q;
      word3_q <= word2_q;
      neg3_q  <= neg2_q;
      ph3_q   <= 55'(hi2_q) * 55'(cfg_i.log_gain);
      pl3_q   <= 63'(lo2_q) * 63'(cfg_i.log_gain);

      word4_q <= word4_d;
    end
  end

  assign valid_o = v4_q;
  assign word_o  = word4_q;

endmodule

`default_nettype wire

// ===== hw/rtl/log2_oetf_with_linear_toe.sv =====
// Log2 camera transfer curve with a linear toe, signed fixed point samples.
// Input channel: in_valid_i / in_stall_o with sample_in_i; a word is taken
// when valid is high and stall is low. Output channel: out_valid_o /
// out_stall_i with sample_out_o, same rule.
// Configuration: cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i;
// ready is always high. Write only while no word is in flight.
// Samples at or below toe_cut are scaled by toe_slope; above it the block
// encodes with log2 (inverse_mode 0) or decodes with exp2 (inverse_mode 1).
// Throughput: one word per cycle while the output is not stalled. A word
// passes four front stages, the 30-step squaring / root-multiply chain,
// four back stages and the output register.
// A stall at the output freezes the whole pipeline while a result is held;
// in_stall_o then rises in the same cycle. Nothing is lost or repeated.
// Reset clears all valid bits and loads the published curve coefficients.
`default_nettype none

module log2_oetf_with_linear_toe #(
  parameter int FRAC_BITS = 24
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  wire logic signed [31:0] sample_in_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output logic signed [31:0] sample_out_o,
  input  wire                cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire [2:0]          cfg_index_i,
  input  wire [31:0]         cfg_data_i
);
  import lote_pkg::*;

  lote_cfg_t          cfg_q;
  logic               en;
  logic               iter_v [0:NumIter];
  lote_iter_t         iter_d [0:NumIter];
  logic               back_v;
  logic signed [31:0] back_word;
  logic               out_v_q;
  logic signed [31:0] out_word_q;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.inverse_mode <= 1'b0;
      cfg_q.offset_a     <= 31'd125829;
      cfg_q.offset_b     <= 32'sd117440512;
      cfg_q.log_gain     <= 31'd1229649;
      cfg_q.toe_slope    <= 31'd175225749;
      cfg_q.toe_cut      <= 32'sd44025;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_INVERSE_MODE: cfg_q.inverse_mode <= cfg_data_i[0];
        REG_OFFSET_A:     cfg_q.offset_a     <= cfg_data_i[30:0];
        REG_OFFSET_B:     cfg_q.offset_b     <= $signed(cfg_data_i);
        REG_LOG_GAIN:     cfg_q.log_gain     <= cfg_data_i[30:0];
        REG_TOE_SLOPE:    cfg_q.toe_slope    <= cfg_data_i[30:0];
        REG_TOE_CUT:      cfg_q.toe_cut      <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Whole pipeline moves unless a finished word is held by the receiver
  assign en         = !(out_v_q && out_stall_i);
  assign in_stall_o = !en;

  lote_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .cfg_i      (cfg_q),
    .valid_i    (in_valid_i),
    .sample_in_i(sample_in_i),
    .valid_o    (iter_v[0]),
    .data_o     (iter_d[0])
  );

  // Squaring / root-multiply chain
  for (genvar g = 1; g <= NumIter; g++) begin : g_iter
    lote_iter_stage #(
      .STAGE(g)
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(iter_v[g-1]),
      .data_i (iter_d[g-1]),
      .valid_o(iter_v[g]),
      .data_o (iter_d[g])
    );
  end

  lote_back #(
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .cfg_i  (cfg_q),
    .valid_i(iter_v[NumIter]),
    .data_i (iter_d[NumIter]),
    .valid_o(back_v),
    .word_o (back_word)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= back_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_word_q <= back_word;
    end
  end

  assign out_valid_o  = out_v_q;
  assign sample_out_o = out_word_q;

`ifndef SYNTHESIS
  a_freeze_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(iter_v[NumIter]) && $stable(iter_v[0]))
    else $error("pipeline moved while output was stalled");

  a_back_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && back_v |=> out_valid_o)
    else $error("finished word did not reach the output");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && !back_v |=> !out_valid_o)
    else $error("output valid without a finished word");
`endif

endmodule

`default_nettype wire

// ===== tb/log2_oetf_with_linear_toe_tb.sv =====
module log2_oetf_with_linear_toe_tb;
  import lote_pkg::*;

  localparam int FracBits = 24;
  localparam int Latency = 39;
  localparam int PhaseItems = 110;
  localparam int HoldCycles = 300;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic signed [31:0] sample_in_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [31:0] sample_out_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i;
  logic [31:0]        cfg_data_i;

  log2_oetf_with_linear_toe #(.FRAC_BITS(FracBits)) dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .sample_in_i,
    .out_valid_o, .out_stall_i, .sample_out_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // Shadow of the register file, updated as writes are accepted
  lote_cfg_t          curve;
  logic signed [31:0] pending_words[$];
  int                 errors;
  int                 words_in;
  int                 words_out;
  int                 cfg_writes;
  int                 src_idle;
  int                 dst_idle;
  int                 hold_left;
  bit                 hold_req;
  bit                 typed_valid;
  logic signed [31:0] typed_word;

  // Directed stimulus: either a register write or a sample
  typedef struct {
    bit                 is_cfg;
    logic [2:0]         idx;
    logic [31:0]        data;
    bit                 has_exp;
    logic signed [31:0] exp_word;
  } step_t;

  step_t directed[] = '{
    '{0, 0, 32'h8000_0000, 1, SAT_MIN},      // toe, most negative: saturates
    '{0, 0, 32'h0000_0000, 1, 32'sd0},       // toe of zero
    '{0, 0, 32'd44025,     0, 0},            // right at the cut
    '{0, 0, 32'd44026,     0, 0},            // just above the cut
    '{0, 0, 32'h7fff_ffff, 0, 0},
    '{0, 0, 32'hffff_ffff, 0, 0},
    '{1, REG_TOE_CUT, 32'h8000_0000, 0, 0},
    '{0, 0, -32'sd125829, 1, SAT_MIN},       // log of zero
    '{0, 0, 32'h8000_0001, 1, SAT_MIN},      // log of negative
    '{0, 0, 32'h0100_0000, 0, 0},
    '{1, REG_INVERSE_MODE, 32'd1, 0, 0},
    '{1, REG_LOG_GAIN, 32'h0100_0000, 0, 0},
    '{1, REG_OFFSET_B, 32'd0, 0, 0},
    '{1, REG_OFFSET_A, 32'd0, 0, 0},
    '{0, 0, 32'h7fff_ffff, 1, SAT_MAX},      // huge exponent
    '{0, 0, 32'h8000_0001, 1, 32'sd0},       // tiny exponent
    '{0, 0, 32'h0100_0000, 0, 0},
    '{1, REG_OFFSET_A, 32'h7fff_ffff, 0, 0},
    '{0, 0, 32'h8000_0001, 1, -32'sh7fff_ffff}, // tiny exponent less offset
    '{1, 3'd6, 32'hdead_beef, 0, 0},         // unknown index, ignored
    '{1, 3'd7, 32'h1234_5678, 0, 0},
    '{0, 0, 32'h0080_0000, 0, 0}
  };

  // Clock
  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Run limit
  initial begin
    #6_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sh7fff_ffff) return SAT_MAX;
    if (v < -64'sh8000_0000) return SAT_MIN;
    return v[31:0];
  endfunction

  function automatic longint unsigned floor_root(input longint unsigned v);
    longint unsigned acc;
    longint unsigned trial;
    acc = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = acc | (64'd1 << b);
      if (trial * trial <= v) acc = trial;
    end
    return acc;
  endfunction

  // Linear toe: round half up, then saturate
  function automatic logic signed [31:0] toe_scale(input longint x);
    return clamp32((x * longint'(curve.toe_slope) + (64'sd1 <<< (FracBits - 1)))
                   >>> FracBits);
  endfunction

  // Forward curve: gain * (log2(x + a) + b)
  function automatic logic signed [31:0] log_encode(input longint x);
    longint            s;
    longint            lg;
    longint unsigned   m;
    longint unsigned   frac;
    longint unsigned   mag;
    longint unsigned   g;
    longint unsigned   r;
    int                msb;
    s = x + longint'(curve.offset_a);
    if (s <= 0) return SAT_MIN;
    msb = 0;
    while (msb < 62 && (s >> (msb + 1)) != 0) msb++;
    m = (msb >= IFRAC) ? (longint'(s) >> (msb - IFRAC)) : (longint'(s) << (IFRAC - msb));
    frac = 0;
    for (int i = 0; i < IFRAC; i++) begin
      m = (m * m) >> IFRAC;
      frac = frac << 1;
      if (m >= (64'd1 << (IFRAC + 1))) begin
        m = m >> 1;
        frac = frac | 64'd1;
      end
    end
    lg = longint'(msb - FracBits) * (64'sd1 <<< IFRAC) + longint'(frac)
         + longint'(curve.offset_b) * (64'sd1 <<< (IFRAC - FracBits));
    mag = (lg < 0) ? longint'(-lg) : longint'(lg);
    g = longint'(curve.log_gain);
    r = (mag >> 32) * g * 4 + (((mag & 64'hffff_ffff) * g + (64'd1 << (IFRAC - 1))) >> IFRAC);
    return clamp32((lg < 0) ? -longint'(r) : longint'(r));
  endfunction

  // Inverse curve: 2^(x * gain - b) - a
  function automatic logic signed [31:0] exp_decode(input longint x);
    longint            e;
    longint            n;
    longint            k;
    longint unsigned   fr;
    longint unsigned   mant;
    longint unsigned   root;
    longint unsigned   pw;
    e = x * longint'(curve.log_gain) - longint'(curve.offset_b) * (64'sd1 <<< FracBits);
    n = e >>> (2 * FracBits);
    fr = (longint'(e) & ((64'd1 << (2 * FracBits)) - 1)) >> (2 * FracBits - IFRAC);
    mant = 64'd1 << IFRAC;
    root = 64'd2 << IFRAC;
    for (int i = 1; i <= IFRAC; i++) begin
      root = floor_root(root << IFRAC);
      if (fr[IFRAC - i]) mant = (mant * root) >> IFRAC;
    end
    k = n + FracBits - IFRAC;
    if (k >= 3) return SAT_MAX;
    if (k < -40) pw = 0;
    else if (k < 0) pw = (mant + (64'd1 << (-k - 1))) >> (-k);
    else pw = mant << k;
    return clamp32(longint'(pw) - longint'(curve.offset_a));
  endfunction

  function automatic logic signed [31:0] curve_out(input logic signed [31:0] x);
    if (x <= curve.toe_cut) return toe_scale(longint'(x));
    if (curve.inverse_mode) return exp_decode(longint'(x));
    return log_encode(longint'(x));
  endfunction

  // Input acceptance and output check
  always @(posedge clk_i) begin
    logic signed [31:0] want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        pending_words.push_back(typed_valid ? typed_word : curve_out(sample_in_i));
        words_in++;
      end
      if (out_valid_o && !out_stall_i) begin
        words_out++;
        if (pending_words.size() == 0) begin
          $display("%0t: unexpected word, actual %0d", $time, sample_out_o);
          errors++;
        end else begin
          want = pending_words.pop_front();
          if (sample_out_o !== want) begin
            $display("%0t: sample_out mismatch, expected %0d actual %0d",
                     $time, want, sample_out_o);
            errors++;
          end
        end
      end
    end
  end

  // Receiver stalls, with an occasional long hold-off
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left <= HoldCycles;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < dst_idle);
    end
  end

  // Called at a falling edge, returns at a falling edge
  task automatic send(input logic signed [31:0] v, input bit has_exp,
                      input logic signed [31:0] exp_word);
    while ($urandom_range(99) < src_idle) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    typed_valid = has_exp;
    typed_word = exp_word;
    in_valid_i <= 1'b1;
    sample_in_i <= v;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    typed_valid = 1'b0;
    while (pending_words.size() != 0) @(negedge clk_i);
    repeat (Latency + 4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_INVERSE_MODE: curve.inverse_mode = data[0];
      REG_OFFSET_A:     curve.offset_a = data[30:0];
      REG_OFFSET_B:     curve.offset_b = data;
      REG_LOG_GAIN:     curve.log_gain = data[30:0];
      REG_TOE_SLOPE:    curve.toe_slope = data[30:0];
      REG_TOE_CUT:      curve.toe_cut = data;
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk_i);
  endtask

  // Extremes, published defaults or random values for one register
  function automatic logic [31:0] pick_reg(input logic [2:0] idx);
    int r;
    r = $urandom_range(9);
    case (idx)
      REG_INVERSE_MODE: return $urandom_range(1);
      REG_OFFSET_A:
        return r == 0 ? 32'd0 : r == 1 ? 32'h7fff_ffff : r < 5 ? 32'd125829
             : r < 8 ? $urandom_range(1 << 25) : $urandom;
      REG_OFFSET_B:
        return r == 0 ? 32'h8000_0000 : r == 1 ? 32'h7fff_ffff : r < 5 ? 32'd117440512
             : r < 8 ? $urandom_range(1 << 29) - (1 << 28) : $urandom;
      REG_LOG_GAIN:
        return r == 0 ? 32'd0 : r == 1 ? 32'h7fff_ffff : r < 4 ? 32'd1229649
             : r < 6 ? 32'd228_000_000 : r < 8 ? $urandom_range(1 << 27) : $urandom;
      REG_TOE_SLOPE:
        return r == 0 ? 32'd0 : r == 1 ? 32'h7fff_ffff : r < 5 ? 32'd175225749
             : r < 8 ? $urandom_range(1 << 27) : $urandom;
      default:
        return r == 0 ? 32'h8000_0000 : r == 1 ? 32'h7fff_ffff : r < 5 ? 32'd44025
             : r < 8 ? $urandom_range(1 << 26) - (1 << 25) : $urandom;
    endcase
  endfunction

  function automatic logic signed [31:0] pick_sample();
    int     r;
    longint near;
    r = $urandom_range(9);
    if (r < 4) return $urandom;
    if (r < 7) return $urandom_range(1 << 27) - (1 << 26);
    if (r < 9) begin
      near = longint'(curve.toe_cut) + $urandom_range(128) - 64;
      return clamp32(near);
    end
    case ($urandom_range(3))
      0: return SAT_MIN;
      1: return SAT_MAX;
      2: return 32'sd0;
      default: return -32'sd1;
    endcase
  endfunction

  // Stimulus
  initial begin
    errors = 0;
    words_in = 0;
    words_out = 0;
    cfg_writes = 0;
    src_idle = 0;
    dst_idle = 0;
    hold_left = 0;
    hold_req = 1'b0;
    typed_valid = 1'b0;
    typed_word = '0;
    in_valid_i = 1'b0;
    sample_in_i = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    curve = '{inverse_mode: 1'b0, offset_a: 31'd125829, offset_b: 32'sd117440512,
              log_gain: 31'd1229649, toe_slope: 31'd175225749, toe_cut: 32'sd44025};
    rst_ni = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part, at the reset curve first
    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        drain();
        write_reg(directed[i].idx, directed[i].data);
        cfg_valid_i <= 1'b0;
      end else begin
        send(directed[i].data, directed[i].has_exp, directed[i].exp_word);
      end
    end
    drain();

    // Random part: three idle profiles, fresh curve each phase
    for (int mode = 0; mode < 3; mode++) begin
      src_idle = mode == 0 ? 6 : mode == 1 ? 46 : 0;
      dst_idle = mode == 0 ? 46 : mode == 1 ? 6 : 0;
      for (int ph = 0; ph < 5; ph++) begin
        drain();
        for (int r = 0; r < 6; r++) write_reg(r[2:0], pick_reg(r[2:0]));
        cfg_valid_i <= 1'b0;
        for (int n = 0; n < PhaseItems; n++) begin
          if (mode == 2 && ph == 1 && n == 5) hold_req = 1'b1;
          if (mode == 2 && ph == 3 && n == PhaseItems / 2) drain();
          send(pick_sample(), 1'b0, '0);
        end
      end
    end
    drain();

    $display("Covered: %0d samples in, %0d words out, %0d register writes,",
             words_in, words_out, cfg_writes);
    $display("toe, log and exp paths with saturation and mixed stall profiles.");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
